// ===== rtl/core/ordered_multiset_table_macros.svh =====
// ----------------------------------------------------------------------------
// Ordered multiset table: assertion macros
// Concurrent checks that drop out of the build when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ORDERED_MULTISET_TABLE_MACROS_SVH
`define ORDERED_MULTISET_TABLE_MACROS_SVH

`ifndef SYNTH

// condition holds at every edge out of reset
`define OMT_ASSERT(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("ordered_multiset_table: check failed");

// consequent holds in the same cycle as the antecedent
`define OMT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ordered_multiset_table: implication failed");

// consequent holds in the cycle after the antecedent
`define OMT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ordered_multiset_table: next-cycle check failed");

`else

`define OMT_ASSERT(lbl, clk, rstn, cond)
`define OMT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define OMT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/core/omt_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered multiset table package
// Capacity, operation and status codes, item and cell types.
// ----------------------------------------------------------------------------
`default_nettype none

package omt_pkg;

    localparam int CAPACITY = 16;
    localparam int USED_W   = 5;
    localparam logic [USED_W-1:0] USED_CAP = USED_W'(CAPACITY);

    // operation codes
    localparam logic [2:0] OP_INSERT   = 3'd0;
    localparam logic [2:0] OP_ERASE    = 3'd1;
    localparam logic [2:0] OP_REMOVE   = 3'd2;
    localparam logic [2:0] OP_COUNT    = 3'd3;
    localparam logic [2:0] OP_AT_MOST  = 3'd4;
    localparam logic [2:0] OP_BELOW    = 3'd5;
    localparam logic [2:0] OP_AT_LEAST = 3'd6;
    localparam logic [2:0] OP_ABOVE    = 3'd7;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_TOO_FEW   = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] key;
        logic [31:0]        amount;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] answer_key;
        logic               found;
        logic [31:0]        key_count;
        logic [31:0]        total_count;
        logic [USED_W-1:0]  distinct_count;
        logic signed [31:0] min_key;
        logic signed [31:0] max_key;
        logic               is_empty;
    } t_out;

    // one table entry
    typedef struct packed {
        logic               vld;
        logic signed [31:0] key;
        logic [31:0]        cnt;
    } t_cell;

    // compare results a cell shows its neighbors and the controller
    typedef struct packed {
        logic lt;
        logic le;
        logic eq;
        logic hit;
        logic last;
    } t_flags;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] key;
        logic [31:0]        cnt_new;
        logic               ins;
        logic               upd;
        logic               del;
    } t_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/ordered_multiset_table.sv =====
// o_valid is registered: after the edge that takes start the item passes the apply and
// readout states, and o_valid rises at the edge leaving readout. busy is high for the cycle
// after acceptance, when the cell row compares, decides and shifts; a new item is taken in
// the following readout cycle. The receiver cannot stall: each result shows for one cycle.
// Reset: the table empties (all cells invalid), counts clear, missing value is 0.
// ----------------------------------------------------------------------------
// Ordered multiset table
// Sorted row of key/count cells with parallel compare, neighbor shift on
// insert and delete, and neighbor queries around a key.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ordered_multiset_table_macros.svh"

module ordered_multiset_table (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire omt_pkg::t_in i_item,
    output logic            o_valid,
    output omt_pkg::t_out   o_result,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [31:0] i_cfg_data
);
    import omt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_APPLY = 3'b010,
        S_READ  = 3'b100
    } t_state;

    t_state             r_state;
    t_state             n_state;
    t_in                r_item;
    logic [USED_W-1:0]  r_used;
    logic [USED_W-1:0]  n_used;
    logic [31:0]        r_total;
    logic [31:0]        n_total;
    logic signed [31:0] r_missing;
    logic [2:0]         r_status;
    logic [2:0]         n_status;
    logic signed [31:0] r_answer;
    logic signed [31:0] n_answer;
    logic               r_found;
    logic               n_found;
    logic               r_valid;
    t_out               r_out;

    t_cell  cell_q   [CAPACITY];
    t_flags flag_q   [CAPACITY];
    logic [31:0] cnt_sel_q  [CAPACITY];
    logic [31:0] hit_key_q  [CAPACITY];
    logic [31:0] last_key_q [CAPACITY];
    logic [CAPACITY-1:0] vld_vec;

    t_ctl ctl;
    logic accept;

    logic        present, hit_any;
    logic [31:0] sel_cnt, hit_key, last_key;
    logic [32:0] sum_t, sum_c, diff;

    assign busy        = (r_state == S_APPLY);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // ---- cell row
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        t_cell  left_c, right_c;
        t_flags left_f, right_f;

        if (gi == 0) begin : g_lo
            assign left_c = '0;
            assign left_f = '{lt: 1'b1, le: 1'b1, eq: 1'b0, hit: 1'b0, last: 1'b0};
        end else begin : g_lo_mid
            assign left_c = cell_q[gi-1];
            assign left_f = flag_q[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_hi
            assign right_c = '0;
            assign right_f = '0;
        end else begin : g_hi_mid
            assign right_c = cell_q[gi+1];
            assign right_f = flag_q[gi+1];
        end

        omt_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_left        (left_c),
            .i_left_flags  (left_f),
            .i_right       (right_c),
            .i_right_flags (right_f),
            .o_cell        (cell_q[gi]),
            .o_flags       (flag_q[gi]),
            .o_cnt_sel     (cnt_sel_q[gi]),
            .o_hit_key     (hit_key_q[gi]),
            .o_last_key    (last_key_q[gi])
        );

        assign vld_vec[gi] = cell_q[gi].vld;
    end

    // ---- merge one-hot cell answers
    always_comb begin
        present  = 1'b0;
        hit_any  = 1'b0;
        sel_cnt  = '0;
        hit_key  = '0;
        last_key = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            present  = present | flag_q[i].eq;
            hit_any  = hit_any | flag_q[i].hit;
            sel_cnt  = sel_cnt | cnt_sel_q[i];
            hit_key  = hit_key | hit_key_q[i];
            last_key = last_key | last_key_q[i];
        end
    end

    // ---- decide the update
    always_comb begin
        sum_t    = {1'b0, r_total} + {1'b0, r_item.amount};
        sum_c    = {1'b0, sel_cnt} + {1'b0, r_item.amount};
        diff     = {1'b0, sel_cnt} - {1'b0, r_item.amount};
        n_status = ST_OK;
        n_used   = r_used;
        n_total  = r_total;
        n_answer = '0;
        n_found  = 1'b0;
        ctl      = '{op: r_item.operation, key: r_item.key, cnt_new: '0,
                     ins: 1'b0, upd: 1'b0, del: 1'b0};
        case (r_item.operation)
            OP_INSERT: begin
                if (r_item.amount != '0) begin
                    if (sum_t[32] || (present && sum_c[32])) begin
                        n_status = ST_OVERFLOW;
                    end else if (present) begin
                        ctl.upd     = 1'b1;
                        ctl.cnt_new = sum_c[31:0];
                        n_total     = sum_t[31:0];
                    end else if (r_used == USED_CAP) begin
                        n_status = ST_FULL;
                    end else begin
                        ctl.ins     = 1'b1;
                        ctl.cnt_new = r_item.amount;
                        n_used      = r_used + USED_W'(1);
                        n_total     = sum_t[31:0];
                    end
                end
            end
            OP_ERASE: begin
                if (present && r_item.amount != '0) begin
                    // saturate at zero: drop the entry when all are taken
                    if (diff[32] || diff[31:0] == '0) begin
                        ctl.del = 1'b1;
                        n_used  = r_used - USED_W'(1);
                        n_total = r_total - sel_cnt;
                    end else begin
                        ctl.upd     = 1'b1;
                        ctl.cnt_new = diff[31:0];
                        n_total     = r_total - r_item.amount;
                    end
                end
            end
            OP_REMOVE: begin
                if (!present) begin
                    n_status = ST_NOT_FOUND;
                end else if (diff[32]) begin
                    n_status = ST_TOO_FEW;
                end else if (r_item.amount != '0) begin
                    n_total = r_total - r_item.amount;
                    if (diff[31:0] == '0) begin
                        ctl.del = 1'b1;
                        n_used  = r_used - USED_W'(1);
                    end else begin
                        ctl.upd     = 1'b1;
                        ctl.cnt_new = diff[31:0];
                    end
                end
            end
            OP_COUNT: begin
                n_found = present;
            end
            OP_AT_MOST, OP_BELOW, OP_AT_LEAST, OP_ABOVE: begin
                n_found  = hit_any;
                n_answer = hit_any ? $signed(hit_key) : r_missing;
            end
            default: begin
                n_found = 1'b0;
            end
        endcase
        // cells move only in the apply cycle
        if (r_state != S_APPLY) begin
            ctl.ins = 1'b0;
            ctl.upd = 1'b0;
            ctl.del = 1'b0;
        end
    end

    // ---- sequencer
    always_comb begin
        case (r_state)
            S_IDLE:  n_state = accept ? S_APPLY : S_IDLE;
            S_APPLY: n_state = S_READ;
            S_READ:  n_state = accept ? S_APPLY : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_total   <= '0;
            r_missing <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_READ);
            if (r_state == S_APPLY) begin
                r_used  <= n_used;
                r_total <= n_total;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_missing <= $signed(i_cfg_data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        if (r_state == S_APPLY) begin
            r_status <= n_status;
            r_answer <= n_answer;
            r_found  <= n_found;
        end
        // read back from the updated row
        if (r_state == S_READ) begin
            r_out.status         <= r_status;
            r_out.answer_key     <= r_answer;
            r_out.found          <= r_found;
            r_out.key_count      <= sel_cnt;
            r_out.total_count    <= r_total;
            r_out.distinct_count <= r_used;
            r_out.min_key        <= cell_q[0].vld ? cell_q[0].key : r_missing;
            r_out.max_key        <= (r_used != '0) ? $signed(last_key) : r_missing;
            r_out.is_empty       <= (r_total == '0);
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

    `OMT_ASSERT(a_used_bound, i_clk, i_rst_n, r_used <= USED_CAP)
    `OMT_ASSERT(a_fill_match, i_clk, i_rst_n, $countones(vld_vec) == int'(r_used))
    `OMT_ASSERT(a_fill_prefix, i_clk, i_rst_n, (vld_vec & (vld_vec + 1'b1)) == '0)
    `OMT_ASSERT_NEXT(a_take_apply, i_clk, i_rst_n, start && !busy, r_state == S_APPLY)
    `OMT_ASSERT_NEXT(a_read_strobe, i_clk, i_rst_n, r_state == S_READ, o_valid)
    `OMT_ASSERT_IMP(a_empty_match, i_clk, i_rst_n, o_valid, o_result.is_empty == (o_result.distinct_count == '0))

endmodule

`default_nettype wire

// ===== rtl/core/omt_cell.sv =====
// ----------------------------------------------------------------------------
// Ordered multiset table cell
// Holds one key and its multiplicity; compares against the broadcast key and
// shifts toward either neighbor on insert or delete.
// ----------------------------------------------------------------------------
`default_nettype none

module omt_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire omt_pkg::t_ctl  i_ctl,
    input  wire omt_pkg::t_cell i_left,
    input  wire omt_pkg::t_flags i_left_flags,
    input  wire omt_pkg::t_cell i_right,
    input  wire omt_pkg::t_flags i_right_flags,
    output omt_pkg::t_cell      o_cell,
    output omt_pkg::t_flags     o_flags,
    output logic [31:0]         o_cnt_sel,
    output logic [31:0]         o_hit_key,
    output logic [31:0]         o_last_key
);
    import omt_pkg::*;

    logic               r_vld;
    logic signed [31:0] r_key;
    logic [31:0]        r_cnt;
    logic               n_vld;
    logic signed [31:0] n_key;
    logic [31:0]        n_cnt;

    logic lt, le, eq, hit, last;

    assign lt   = r_vld && (r_key <  i_ctl.key);
    assign le   = r_vld && (r_key <= i_ctl.key);
    assign eq   = r_vld && (r_key == i_ctl.key);
    assign last = r_vld && !i_right.vld;

    always_comb begin
        case (i_ctl.op)
            OP_AT_MOST:  hit = le && !i_right_flags.le;
            OP_BELOW:    hit = lt && !i_right_flags.lt;
            OP_AT_LEAST: hit = r_vld && !lt && i_left_flags.lt;
            OP_ABOVE:    hit = r_vld && !le && i_left_flags.le;
            default:     hit = 1'b0;
        endcase
    end

    always_comb begin
        n_vld = r_vld;
        n_key = r_key;
        n_cnt = r_cnt;
        if (i_ctl.ins && !lt) begin
            if (i_left_flags.lt) begin
                n_vld = 1'b1;
                n_key = i_ctl.key;
                n_cnt = i_ctl.cnt_new;
            end else begin
                // make room: take the lower neighbor's entry
                n_vld = i_left.vld;
                n_key = i_left.key;
                n_cnt = i_left.cnt;
            end
        end else if (i_ctl.del && !lt) begin
            // close the gap: take the upper neighbor's entry
            n_vld = i_right.vld;
            n_key = i_right.key;
            n_cnt = i_right.cnt;
        end else if (i_ctl.upd && eq) begin
            n_cnt = i_ctl.cnt_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_cnt <= n_cnt;
    end

    assign o_cell     = '{vld: r_vld, key: r_key, cnt: r_cnt};
    assign o_flags    = '{lt: lt, le: le, eq: eq, hit: hit, last: last};
    assign o_cnt_sel  = eq   ? r_cnt : '0;
    assign o_hit_key  = hit  ? r_key : '0;
    assign o_last_key = last ? r_key : '0;

endmodule

`default_nettype wire
